@@ src/salru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative tag store with
// age-based LRU replacement.
// ----------------------------------------------------------------------------
package salru_pkg;

	localparam int MAX_SETS   = 64;
	localparam int SET_W      = $clog2(MAX_SETS);
	localparam int MAX_WAYS   = 8;
	localparam int WAY_W      = 3;
	localparam int NWAY_W     = 4;
	localparam int ADDR_W     = 32;
	localparam int AGE_W      = 16;
	localparam int OFFSET_W   = 4;
	localparam int INDEX_W    = 3;
	localparam int SHIFT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX   = OFFSET_W'(12);
	localparam logic [INDEX_W-1:0]  INDEX_MAX    = INDEX_W'(SET_W);
	localparam logic [NWAY_W-1:0]   WAYS_MAX     = NWAY_W'(MAX_WAYS);
	localparam logic [AGE_W-1:0]    AGE_MAX      = '1;

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(2);
	localparam logic [INDEX_W-1:0]  INDEX_RESET  = INDEX_W'(4);
	localparam logic [NWAY_W-1:0]   WAYS_RESET   = NWAY_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_INDEX_BITS  = 2'd1,
		CFG_WAYS_USED   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_LOOKUP = 1'b1
	} lookup_state_t;

	typedef struct packed {
		logic             valid;
		logic [ADDR_W-1:0] tag;
		logic [AGE_W-1:0]  age;
	} way_entry_t;

	typedef way_entry_t [MAX_WAYS-1:0] set_row_t;

endpackage

@@ src/set_assoc_cache_lru_lookup_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_unit
// Tag store of a set-associative cache: one set row per memory entry, read,
// searched, aged and written back for every looked-up address.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | address[31:0]
//  out     | output    | out_valid/out_ready | hit, way[2:0]
//  cfg     | input     | cfg_wr_en           | cfg_idx[1:0], cfg_data[3:0]
//
// For each address the set row is read from the synchronous memory at accept,
// then searched, updated and written back once the output register is free.
// One address is in flight at a time, so a read never overlaps a write.
// Reset clears the per-set valid flags at once; no clearing pass is needed.
// A result waiting in the output register does not block the next accept;
// only the write-back of the following address waits for it to leave.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_unit
	import salru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ADDR_W-1:0]     address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [WAY_W-1:0]      way,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [OFFSET_W-1:0] offset_bits_q;
	logic [INDEX_W-1:0]  index_bits_q;
	logic [NWAY_W-1:0]   ways_used_q;

	lookup_state_t state_q, state_d;

	logic                rd_en;
	logic                finish;
	logic [OFFSET_W-1:0] ob_eff;
	logic [INDEX_W-1:0]  ib_eff;
	logic [NWAY_W-1:0]   nw_eff;
	logic [ADDR_W-1:0]   addr_sh;
	logic [SET_W:0]      set_span;
	logic [SET_W-1:0]    set_mask;
	logic [SET_W-1:0]    rd_set;
	logic [SHIFT_W-1:0]  tag_shift;
	logic [ADDR_W-1:0]   tag_in;

	set_row_t            row_mem [MAX_SETS];
	logic [MAX_SETS-1:0] row_init_q;

	set_row_t          rd_row_s1;
	logic              rd_init_s1;
	logic [SET_W-1:0]  set_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [NWAY_W-1:0] nw_s1;

	logic [MAX_WAYS-1:0] in_use;
	logic [MAX_WAYS-1:0] eff_valid;
	logic [AGE_W-1:0]    eff_age [MAX_WAYS];
	logic                hit_found;
	logic [WAY_W-1:0]    hit_way;
	logic [AGE_W-1:0]    best_age;
	logic [WAY_W-1:0]    victim;
	logic [WAY_W-1:0]    chosen;
	set_row_t            new_row;

	logic             out_valid_q;
	logic             hit_q;
	logic [WAY_W-1:0] way_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= OFFSET_RESET;
			index_bits_q  <= INDEX_RESET;
			ways_used_q   <= WAYS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data[OFFSET_W-1:0];
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data[INDEX_W-1:0];
				CFG_WAYS_USED:   ways_used_q   <= cfg_data[NWAY_W-1:0];
				default: ;
			endcase
		end
	end

	// address split
	always_comb begin
		ob_eff    = (offset_bits_q > OFFSET_MAX) ? OFFSET_MAX : offset_bits_q;
		ib_eff    = (index_bits_q > INDEX_MAX) ? INDEX_MAX : index_bits_q;
		if (ways_used_q == '0)
			nw_eff = NWAY_W'(1);
		else if (ways_used_q > WAYS_MAX)
			nw_eff = WAYS_MAX;
		else
			nw_eff = ways_used_q;
		addr_sh   = address >> ob_eff;
		set_span  = (SET_W+1)'(1) << ib_eff;
		set_mask  = SET_W'(set_span - 1'b1);
		rd_set    = addr_sh[SET_W-1:0] & set_mask;
		tag_shift = SHIFT_W'(ob_eff) + SHIFT_W'(ib_eff);
		tag_in    = address >> tag_shift;
	end

	// control
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_LOOKUP: finish   = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign rd_en = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// set memory: one row per set, read at accept, written at finish
	always_ff @(posedge clk) begin
		if (finish)
			row_mem[set_s1] <= new_row;
		if (rd_en)
			rd_row_s1 <= row_mem[rd_set];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_init_s1 <= row_init_q[rd_set];
			set_s1     <= rd_set;
			tag_s1     <= tag_in;
			nw_s1      <= nw_eff;
		end
	end

	// a row never written reads as all ways invalid with age zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_init_q <= '0;
		else if (finish)
			row_init_q[set_s1] <= 1'b1;
	end

	// search, victim choice and aging
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w]    = NWAY_W'(w) < nw_s1;
			eff_valid[w] = rd_init_s1 && rd_row_s1[w].valid;
			eff_age[w]   = rd_init_s1 ? rd_row_s1[w].age : '0;
		end

		hit_found = 1'b0;
		hit_way   = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (in_use[w] && eff_valid[w] && rd_row_s1[w].tag == tag_s1) begin
				hit_found = 1'b1;
				hit_way   = WAY_W'(w);
			end
		end

		// strict compare keeps the lowest way on ties
		best_age = eff_age[0];
		victim   = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && eff_age[w] > best_age) begin
				best_age = eff_age[w];
				victim   = WAY_W'(w);
			end
		end

		chosen = hit_found ? hit_way : victim;

		for (int w = 0; w < MAX_WAYS; w++) begin
			new_row[w].valid = eff_valid[w];
			new_row[w].tag   = rd_row_s1[w].tag;
			new_row[w].age   = eff_age[w];
			if (WAY_W'(w) == chosen) begin
				new_row[w].age = '0;
				if (!hit_found) begin
					new_row[w].valid = 1'b1;
					new_row[w].tag   = tag_s1;
				end
			end else if (in_use[w] && eff_age[w] < AGE_MAX) begin
				new_row[w].age = eff_age[w] + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q <= hit_found;
			way_q <= chosen;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign way       = way_q;

endmodule

@@ src/salru_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks of the tag store lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module salru_checker
	import salru_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             hit,
	input logic [WAY_W-1:0] way
);

	// one address in flight: the cycle after an accept takes nothing
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a lookup is in flight");

	// a new result appears only as a lookup completes
	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a lookup in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(hit) && $stable(way)))
		else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_lookup_unit salru_checker u_salru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.way       (way)
);
